/* rtl/stt_pkg.sv */
`default_nettype none
package stt_pkg;

  localparam int MaxWordLenDefault   = 30;
  localparam int KeywordBytesDefault = 12;
  localparam int KwCount             = 21;

  // Scanner modes.
  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_NUM     = 4'd1,
    MODE_WORD    = 4'd2,
    MODE_COLON   = 4'd3,
    MODE_LT      = 4'd4,
    MODE_GT      = 4'd5,
    MODE_BANG    = 4'd6,
    MODE_COMMENT = 4'd7
  } mode_e;

  // Token kinds.
  localparam logic [5:0] KIND_NUMBER  = 6'd0;
  localparam logic [5:0] KIND_IDENT   = 6'd1;
  localparam logic [5:0] KIND_KW_BASE = 6'd2;
  localparam logic [5:0] KIND_ASSIGN  = 6'd23;
  localparam logic [5:0] KIND_COLON   = 6'd24;
  localparam logic [5:0] KIND_PLUS    = 6'd25;
  localparam logic [5:0] KIND_MINUS   = 6'd26;
  localparam logic [5:0] KIND_STAR    = 6'd27;
  localparam logic [5:0] KIND_LT      = 6'd28;
  localparam logic [5:0] KIND_LE      = 6'd29;
  localparam logic [5:0] KIND_GT      = 6'd30;
  localparam logic [5:0] KIND_GE      = 6'd31;
  localparam logic [5:0] KIND_EQ      = 6'd32;
  localparam logic [5:0] KIND_NE      = 6'd33;
  localparam logic [5:0] KIND_SEMI    = 6'd34;
  localparam logic [5:0] KIND_COMMA   = 6'd35;
  localparam logic [5:0] KIND_LPAREN  = 6'd36;
  localparam logic [5:0] KIND_RPAREN  = 6'd37;
  localparam logic [5:0] KIND_DOT     = 6'd38;
  localparam logic [5:0] KIND_INVALID = 6'd39;
  localparam logic [5:0] KIND_ERROR   = 6'd40;

  // Error codes.
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_LETTER   = 3'd1;
  localparam logic [2:0] ERR_LONG     = 3'd2;
  localparam logic [2:0] ERR_COMMENT  = 3'd3;
  localparam logic [2:0] ERR_INVALID  = 3'd4;

  // One result item.
  typedef struct packed {
    logic [5:0]  kind;
    logic [2:0]  err;
    logic [31:0] line;
    logic [31:0] start;
    logic [7:0]  len;
    logic        last;
  } token_t;

  // Keyword table, up to 16 bytes, first byte in the low byte.
  typedef struct packed {
    logic [4:0]   len;
    logic [127:0] text;
  } kw_t;

  function automatic kw_t kw_entry(input int idx);
    kw_t k;
    k = '0;
    case (idx)
      0:  begin k.len = 5'd8;  k.text[63:0] = 64'h616d6172676f7270; end
      1:  begin k.len = 5'd2;  k.text[15:0] = 16'h6573; end
      2:  begin k.len = 5'd5;  k.text[39:0] = 40'h6f6174_6e65; end
      3:  begin k.len = 5'd5;  k.text[39:0] = 40'h6f616e6573; end
      4:  begin k.len = 5'd8;  k.text[63:0] = 64'h6f746e6175716e65; end
      5:  begin k.len = 5'd4;  k.text[31:0] = 32'h61636166; end
      6:  begin k.len = 5'd6;  k.text[47:0] = 48'h6f6963696e69; end
      7:  begin k.len = 5'd3;  k.text[23:0] = 24'h6d6966; end
      8:  begin k.len = 5'd7;  k.text[55:0] = 56'h61766572637365; end
      9:  begin k.len = 5'd4;  k.text[31:0] = 32'h6169656c; end
      10: begin k.len = 5'd3;  k.text[23:0] = 24'h726176; end
      11: begin k.len = 5'd7;  k.text[55:0] = 56'h6f726965746e69; end
      12: begin k.len = 5'd8;  k.text[63:0] = 64'h6f6e61656c6f6f62; end
      13: begin k.len = 5'd10; k.text[79:0] = 80'h6f726965646164726576; end
      14: begin k.len = 5'd5;  k.text[39:0] = 40'h6f736c6166; end
      15: begin k.len = 5'd12; k.text[95:0] = 96'h6f746e656d696465636f7270; end
      16: begin k.len = 5'd6;  k.text[47:0] = 48'h6f6163_6e7566; end
      17: begin k.len = 5'd3;  k.text[23:0] = 24'h766964; end
      18: begin k.len = 5'd1;  k.text[7:0]  = 8'h65; end
      19: begin k.len = 5'd2;  k.text[15:0] = 16'h756f; end
      20: begin k.len = 5'd3;  k.text[23:0] = 24'h6f616e; end
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a));
  endfunction

endpackage
`default_nettype wire

/* rtl/source_text_tokenizer_core.sv */
// Source text tokenizer.
// Input channel: one beat per source byte (text_byte_i), or an end marker
// (end_of_text_i) that flushes the pending token and reports an open comment.
// Output channel: one beat per token, with kind, error code, line, start
// position, length and last_of_run marking the final token caused by a beat.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// Throughput: one input beat per cycle while not stalled; a beat yields up to
// two tokens, so the output side (one token per cycle while the receiver does
// not stall) sets the sustained rate under dense tokens. Each token is written
// to the four-entry token queue, then loaded into the output register.
// The front stalls when the queue has fewer than two free entries.
// Reset clears the scanner to idle, the line counter to one, positions to zero
// and empties the queue and the output register.
// While the receiver stalls, the output beat holds and the queue fills.
`default_nettype none
module source_text_tokenizer_core
  import stt_pkg::*;
#(
  parameter int MaxWordLen   = MaxWordLenDefault,
  parameter int KeywordBytes = KeywordBytesDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic [7:0]  text_byte_i,
  input  wire logic        end_of_text_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [5:0]       token_kind_o,
  output logic [2:0]       error_code_o,
  output logic [31:0]      line_number_o,
  output logic [31:0]      start_position_o,
  output logic [7:0]       lexeme_length_o,
  output logic             last_of_run_o
);

  logic       room, push, q_valid, q_stall;
  logic [1:0] push_cnt;
  token_t     tok0, tok1, head, tok;

  stt_front #(.MaxWordLen(MaxWordLen), .KeywordBytes(KeywordBytes)) u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .text_byte_i, .end_of_text_i,
    .q_room_i(room), .push_o(push), .push_cnt_o(push_cnt),
    .tok0_o(tok0), .tok1_o(tok1)
  );

  stt_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_cnt_i(push_cnt),
    .tok0_i(tok0), .tok1_i(tok1), .room_o(room),
    .valid_o(q_valid), .stall_i(q_stall), .head_o(head)
  );

  stt_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_stall_o(q_stall), .head_i(head),
    .valid_o, .stall_i, .tok_o(tok)
  );

  assign token_kind_o     = tok.kind;
  assign error_code_o     = tok.err;
  assign line_number_o    = tok.line;
  assign start_position_o = tok.start;
  assign lexeme_length_o  = tok.len;
  assign last_of_run_o    = tok.last;

endmodule
`default_nettype wire

/* rtl/stt_front.sv */
`default_nettype none
module stt_front
  import stt_pkg::*;
#(
  parameter int MaxWordLen   = MaxWordLenDefault,
  parameter int KeywordBytes = KeywordBytesDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            stall_o,
  input  wire logic [7:0] text_byte_i,
  input  wire logic       end_of_text_i,
  // Queue side: space for two tokens and the push.
  input  wire logic       q_room_i,
  output logic            push_o,
  output logic [1:0]      push_cnt_o,
  output token_t          tok0_o,
  output token_t          tok1_o
);

  mode_e       mode_q, mode_d;
  logic [7:0]  wbytes_q [KeywordBytes];
  logic [7:0]  wlen_q, wlen_d;
  logic [31:0] line_q, line_d, pos_q, pos_d, tstart_q, tstart_d;

  logic        acc;
  logic [7:0]  c;
  logic [5:0]  wkind;
  logic        wr_byte;
  logic [7:0]  wr_idx;
  token_t      t0, t1;
  logic [1:0]  cnt;

  assign stall_o = !q_room_i;
  assign acc     = valid_i && q_room_i;
  assign c       = text_byte_i;

  // Parallel keyword match on the stored word.
  always_comb begin
    kw_t e;
    logic hit;
    wkind = KIND_IDENT;
    for (int i = KwCount - 1; i >= 0; i--) begin
      e   = kw_entry(i);
      hit = (wlen_q == {3'b000, e.len}) && (e.len <= 5'(KeywordBytes));
      for (int b = 0; b < KeywordBytes; b++) begin
        if ((b < int'(e.len)) && (wbytes_q[b] != e.text[b*8 +: 8])) hit = 1'b0;
      end
      if (hit) wkind = KIND_KW_BASE + 6'(i);
    end
  end

  // Scanner next state and emitted tokens.
  always_comb begin
    logic       wc;
    logic       need_start;
    token_t     tk;
    logic       tv;
    mode_d     = mode_q;
    wlen_d     = wlen_q;
    line_d     = line_q;
    pos_d      = pos_q;
    tstart_d   = tstart_q;
    wr_byte    = 1'b0;
    wr_idx     = 8'd0;
    t0         = '0;
    t1         = '0;
    cnt        = 2'd0;
    need_start = 1'b0;
    tk         = '0;
    tv         = 1'b0;
    wc = is_letter(c) || is_digit(c) || (c == 8'h5f);
    t0.line = line_q;
    t1.line = line_q;
    if (end_of_text_i) begin
      tv = 1'b1;
      tk.line = line_q;
      tk.start = tstart_q;
      tk.len = 8'd1;
      case (mode_q)
        MODE_NUM:     begin tk.kind = KIND_NUMBER; tk.len = wlen_q; end
        MODE_WORD:    begin tk.kind = wkind; tk.len = wlen_q; end
        MODE_COLON:   tk.kind = KIND_COLON;
        MODE_LT:      tk.kind = KIND_LT;
        MODE_GT:      tk.kind = KIND_GT;
        MODE_BANG:    begin tk.kind = KIND_INVALID; tk.err = ERR_INVALID; end
        MODE_COMMENT: begin
          tk.kind = KIND_ERROR; tk.err = ERR_COMMENT; tk.start = pos_q; tk.len = 8'd0;
        end
        default:      tv = 1'b0;
      endcase
      mode_d = MODE_IDLE;
      wlen_d = 8'd0;
      if (tv) begin t0 = tk; cnt = 2'd1; end
    end else begin
      pos_d = pos_q + 32'd1;
      tk.line = line_q;
      tk.start = tstart_q;
      case (mode_q)
        MODE_NUM: begin
          if (is_digit(c)) begin
            if (wlen_q != 8'hff) wlen_d = wlen_q + 8'd1;
          end else begin
            tv = 1'b1; tk.kind = KIND_NUMBER; tk.len = wlen_q;
            tk.err = (is_letter(c) || c == 8'h5f) ? ERR_LETTER : ERR_NONE;
            need_start = 1'b1;
          end
        end
        MODE_WORD: begin
          if (wc && (wlen_q < 8'(MaxWordLen))) begin
            if (wlen_q < 8'(KeywordBytes)) begin wr_byte = 1'b1; wr_idx = wlen_q; end
            wlen_d = wlen_q + 8'd1;
          end else begin
            tv = 1'b1; tk.kind = wkind; tk.len = wlen_q;
            tk.err = wc ? ERR_LONG : ERR_NONE;
            need_start = 1'b1;
          end
        end
        MODE_COLON, MODE_LT, MODE_GT, MODE_BANG: begin
          tv = 1'b1;
          if (c == 8'h3d) begin
            tk.len = 8'd2;
            mode_d = MODE_IDLE;
            case (mode_q)
              MODE_COLON: tk.kind = KIND_ASSIGN;
              MODE_LT:    tk.kind = KIND_LE;
              MODE_GT:    tk.kind = KIND_GE;
              default:    tk.kind = KIND_NE;
            endcase
          end else begin
            tk.len = 8'd1;
            need_start = 1'b1;
            case (mode_q)
              MODE_COLON: tk.kind = KIND_COLON;
              MODE_LT:    tk.kind = KIND_LT;
              MODE_GT:    tk.kind = KIND_GT;
              default:    begin tk.kind = KIND_INVALID; tk.err = ERR_INVALID; end
            endcase
          end
        end
        MODE_COMMENT: begin
          if (c == 8'h0a) line_d = line_q + 32'd1;
          else if (c == 8'h7d) mode_d = MODE_IDLE;
          else if (c == 8'h7b) begin
            tv = 1'b1; tk.kind = KIND_ERROR; tk.err = ERR_COMMENT;
            tk.start = pos_q; tk.len = 8'd0; mode_d = MODE_IDLE;
          end
        end
        default: need_start = 1'b1;
      endcase
      if (tv) begin t0 = tk; cnt = 2'd1; end
      // The current byte opens a new token.
      if (need_start) begin
        token_t ts;
        logic   sv;
        ts = '0;
        ts.line = line_q;
        ts.start = pos_q;
        ts.len = 8'd1;
        sv = 1'b0;
        mode_d = MODE_IDLE;
        if (c == 8'h20 || c == 8'h09) begin
        end else if (c == 8'h0a) begin
          line_d = line_q + 32'd1;
        end else if (c == 8'h7b) begin
          mode_d = MODE_COMMENT;
        end else if (is_digit(c)) begin
          mode_d = MODE_NUM; tstart_d = pos_q; wlen_d = 8'd1;
        end else if (is_letter(c)) begin
          mode_d = MODE_WORD; tstart_d = pos_q; wlen_d = 8'd1;
          wr_byte = 1'b1; wr_idx = 8'd0;
        end else begin
          tstart_d = pos_q;
          sv = 1'b1;
          case (c)
            8'h3a: begin mode_d = MODE_COLON; sv = 1'b0; end
            8'h3c: begin mode_d = MODE_LT; sv = 1'b0; end
            8'h3e: begin mode_d = MODE_GT; sv = 1'b0; end
            8'h21: begin mode_d = MODE_BANG; sv = 1'b0; end
            8'h3d: ts.kind = KIND_EQ;
            8'h2b: ts.kind = KIND_PLUS;
            8'h2d: ts.kind = KIND_MINUS;
            8'h2a: ts.kind = KIND_STAR;
            8'h3b: ts.kind = KIND_SEMI;
            8'h2c: ts.kind = KIND_COMMA;
            8'h28: ts.kind = KIND_LPAREN;
            8'h29: ts.kind = KIND_RPAREN;
            8'h2e: ts.kind = KIND_DOT;
            default: begin ts.kind = KIND_INVALID; ts.err = ERR_INVALID; end
          endcase
        end
        if (sv) begin
          if (tv) begin t1 = ts; cnt = 2'd2; end
          else begin t0 = ts; cnt = 2'd1; end
        end
      end
    end
    if (cnt == 2'd1) t0.last = 1'b1;
    if (cnt == 2'd2) t1.last = 1'b1;
  end

  assign push_o     = acc && (cnt != 2'd0);
  assign push_cnt_o = cnt;
  assign tok0_o     = t0;
  assign tok1_o     = t1;

  // Scanner state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      wlen_q   <= 8'd0;
      line_q   <= 32'd1;
      pos_q    <= 32'd0;
      tstart_q <= 32'd0;
    end else if (acc) begin
      mode_q   <= mode_d;
      wlen_q   <= wlen_d;
      line_q   <= line_d;
      pos_q    <= pos_d;
      tstart_q <= tstart_d;
    end
  end

  // Stored word bytes for keyword matching.
  always_ff @(posedge clk_i) begin
    if (acc && wr_byte) wbytes_q[wr_idx[$clog2(KeywordBytes)-1:0]] <= c;
  end

endmodule
`default_nettype wire

/* rtl/stt_queue.sv */
`default_nettype none
module stt_queue
  import stt_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire logic [1:0] push_cnt_i,
  input  wire token_t tok0_i,
  input  wire token_t tok1_i,
  output logic        room_o,
  output logic        valid_o,
  input  wire logic   stall_i,
  output token_t      head_o
);

  // Four-entry ring; room means at least two free entries.
  token_t     mem_q [4];
  logic [1:0] rd_q, wr_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign valid_o = (cnt_q != 3'd0);
  assign pop     = valid_o && !stall_i;
  assign room_o  = (cnt_q <= 3'd2);
  assign head_o  = mem_q[rd_q];

  // Pointer and count update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 2'd0;
      wr_q  <= 2'd0;
      cnt_q <= 3'd0;
    end else begin
      if (pop) rd_q <= rd_q + 2'd1;
      if (push_i) wr_q <= wr_q + push_cnt_i;
      cnt_q <= cnt_q + (push_i ? {1'b0, push_cnt_i} : 3'd0) - {2'b00, pop};
    end
  end

  // Storage writes.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= tok0_i;
      if (push_cnt_i == 2'd2) mem_q[wr_q + 2'd1] <= tok1_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/stt_back.sv */
`default_nettype none
module stt_back
  import stt_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   q_valid_i,
  output logic        q_stall_o,
  input  wire token_t head_i,
  output logic        valid_o,
  input  wire logic   stall_i,
  output token_t      tok_o
);

  // Output register refilled whenever empty or taken.
  logic   vld_q;
  token_t tok_q;
  logic   load;

  assign load      = q_valid_i && (!vld_q || !stall_i);
  assign q_stall_o = !(!vld_q || !stall_i);
  assign valid_o   = vld_q;
  assign tok_o     = tok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (!vld_q || !stall_i) vld_q <= q_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (load) tok_q <= head_i;
  end

endmodule
`default_nettype wire

/* rtl/stt_checker.sv */
`default_nettype none
module stt_checker
  import stt_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       valid_o,
  input wire logic       stall_i,
  input wire logic [5:0] token_kind_o,
  input wire logic [2:0] error_code_o,
  input wire logic [7:0] lexeme_length_o
);

  // A stalled beat keeps its kind.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(token_kind_o))
    else $error("stalled token changed");

  // Error-only tokens carry the comment error and no length.
  a_err_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && token_kind_o == KIND_ERROR |->
      error_code_o == ERR_COMMENT && lexeme_length_o == 8'd0)
    else $error("bad error-only token");

  // Invalid symbols are one byte with the invalid error.
  a_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && token_kind_o == KIND_INVALID |->
      error_code_o == ERR_INVALID && lexeme_length_o == 8'd1)
    else $error("bad invalid token");

  // Kinds stay within the defined range.
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> token_kind_o <= KIND_ERROR)
    else $error("kind out of range");

endmodule

bind source_text_tokenizer_core stt_checker u_checker (
  .clk_i, .rst_ni, .valid_o, .stall_i, .token_kind_o, .error_code_o, .lexeme_length_o
);
`default_nettype wire
